// ===== hdl/akd_pkg.sv =====
// ----------------------------------------------------------------------------
// Ackermann drive kinematics package
// Shared widths, constants, pipeline slot types and helper functions.
// ----------------------------------------------------------------------------
package akd_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned AXLE_W     = 11;
    localparam int unsigned TRACK_W    = 11;
    localparam int unsigned WHEEL_W    = 10;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned RADIUS_W   = 18;
    localparam int unsigned RPS_W      = 32;
    localparam int unsigned PULSE_W    = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_AXLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL = 2'd2;

    localparam logic [AXLE_W-1:0]  AXLE_RESET  = 11'd200;
    localparam logic [TRACK_W-1:0] TRACK_RESET = 11'd160;
    localparam logic [WHEEL_W-1:0] WHEEL_RESET = 10'd65;

    localparam int unsigned ANGLE_FRAC_BITS_DEF = 14;
    localparam int unsigned CORDIC_STAGES_DEF   = 16;
    localparam int unsigned ATAN_TABLE_LEN      = 24;
    localparam int unsigned CORDIC_PRESHIFT     = 20;

    localparam logic [22:0]          INV_PI_Q24   = 23'd5340354;
    localparam int unsigned          K_Q16_W      = 26;
    localparam logic [K_Q16_W-1:0]   K_Q16        = 26'd41721514;
    localparam logic [63:0]          LIMIT_Q30    = 64'd749613206;
    localparam logic [PULSE_W-1:0]   PULSE_CENTRE = 11'd1500;
    localparam logic [PULSE_W-1:0]   PULSE_MIN    = 11'd1056;
    localparam logic [PULSE_W-1:0]   PULSE_MAX    = 11'd1944;

    localparam int unsigned COR_XW    = 41;
    localparam int unsigned COR_ZW    = 33;
    localparam int unsigned DIV_REM_W = 57;
    localparam int unsigned DIV_DEN_W = 37;
    localparam int unsigned DIV_QUO_W = 33;

    localparam logic [DIV_QUO_W-1:0] QUO_NEG_LIM = 33'h0_8000_0000;
    localparam logic [DIV_QUO_W-1:0] QUO_POS_LIM = 33'h0_7FFF_FFFF;

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_QUO_W-1:0] quo;
        logic                 neg;
        logic                 ovf;
    } div_slot_t;

    typedef struct packed {
        logic signed [COR_XW-1:0] x;
        logic signed [COR_XW-1:0] y;
        logic signed [COR_ZW-1:0] z;
        logic                     rneg;
        logic                     straight;
    } cor_slot_t;

    function automatic logic signed [COR_ZW-1:0] akd_atan(input int unsigned idx);
        unique case (idx)
            0:       return COR_ZW'(843314857);
            1:       return COR_ZW'(497837829);
            2:       return COR_ZW'(263043837);
            3:       return COR_ZW'(133525159);
            4:       return COR_ZW'(67021687);
            5:       return COR_ZW'(33543516);
            6:       return COR_ZW'(16775851);
            7:       return COR_ZW'(8388437);
            8:       return COR_ZW'(4194283);
            9:       return COR_ZW'(2097149);
            10:      return COR_ZW'(1048576);
            11:      return COR_ZW'(524288);
            12:      return COR_ZW'(262144);
            13:      return COR_ZW'(131072);
            14:      return COR_ZW'(65536);
            15:      return COR_ZW'(32768);
            16:      return COR_ZW'(16384);
            17:      return COR_ZW'(8192);
            18:      return COR_ZW'(4096);
            19:      return COR_ZW'(2048);
            20:      return COR_ZW'(1024);
            21:      return COR_ZW'(512);
            22:      return COR_ZW'(256);
            23:      return COR_ZW'(128);
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [RPS_W-1:0] akd_saturate(input div_slot_t s);
        logic [DIV_QUO_W-1:0] mag;
        if (s.neg)
        begin
            mag = (s.ovf || s.quo > QUO_NEG_LIM) ? QUO_NEG_LIM : s.quo;
            return RPS_W'(-$signed({1'b0, mag}));
        end
        else
        begin
            mag = (s.ovf || s.quo > QUO_POS_LIM) ? QUO_POS_LIM : s.quo;
            return RPS_W'(mag);
        end
    endfunction

endpackage

// ===== hdl/akd_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: settles one quotient bit and passes the slot on.
// ----------------------------------------------------------------------------
module akd_div_cell
    import akd_pkg::*;
#(
    parameter int unsigned BIT = 0
)
(
    input  logic      clk,
    input  div_slot_t slot_in,
    output div_slot_t slot_out
);

    localparam int unsigned CMP_W = (DIV_DEN_W + BIT > DIV_REM_W) ?
                                    DIV_DEN_W + BIT : DIV_REM_W;

    logic [CMP_W-1:0] rem_x;
    logic [CMP_W-1:0] den_x;
    logic             ge;
    div_slot_t        slot_next;
    div_slot_t        slot_reg;

    assign rem_x = CMP_W'(slot_in.rem);
    assign den_x = CMP_W'(slot_in.den) << BIT;
    assign ge    = rem_x >= den_x;

    always_comb
    begin
        slot_next = slot_in;
        if (ge)
        begin
            slot_next.rem      = DIV_REM_W'(rem_x - den_x);
            slot_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_out = slot_reg;

endmodule

// ===== hdl/akd_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation that drives y towards zero and accumulates the angle.
// ----------------------------------------------------------------------------
module akd_cordic_cell
    import akd_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  logic      clk,
    input  cor_slot_t slot_in,
    output cor_slot_t slot_out
);

    localparam logic signed [COR_ZW-1:0] ANGLE = akd_atan(IDX);

    logic signed [COR_XW-1:0] xs;
    logic signed [COR_XW-1:0] ys;
    cor_slot_t                slot_next;
    cor_slot_t                slot_reg;

    assign xs = slot_in.x >>> IDX;
    assign ys = slot_in.y >>> IDX;

    always_comb
    begin
        slot_next = slot_in;
        if (!slot_in.y[COR_XW-1])
        begin
            slot_next.x = slot_in.x + ys;
            slot_next.y = slot_in.y - xs;
            slot_next.z = slot_in.z + ANGLE;
        end
        else
        begin
            slot_next.x = slot_in.x - ys;
            slot_next.y = slot_in.y + xs;
            slot_next.z = slot_in.z - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_out = slot_reg;

endmodule

// ===== hdl/ackermann_drive_kinematics.sv =====
// ----------------------------------------------------------------------------
// Ackermann drive kinematics
// Wheel speeds and steering servo pulse from a forward speed and turn radius.
// ----------------------------------------------------------------------------
// The block is fully pipelined and takes a new request in every clock cycle;
// busy never rises. A request accepted at one clock edge yields its result on
// the output ports, marked by done, for a single cycle, after it has passed the
// three set-up stages, the 33 cells of each wheel divider chain and the
// output register; the steering CORDIC cells run alongside and are
// delayed to match. The receiver must take each result in that cycle.
// Configuration writes take effect at once and should be made only while no
// request is in flight.
module ackermann_drive_kinematics
    import akd_pkg::*;
#(
    parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int unsigned CORDIC_STAGES   = CORDIC_STAGES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SPEED_W-1:0]  forward_speed,
    input  logic signed [RADIUS_W-1:0] turn_radius,
    output logic                       done,
    output logic signed [RPS_W-1:0]    left_rps,
    output logic signed [RPS_W-1:0]    right_rps,
    output logic [PULSE_W-1:0]         steer_pulse
);

    localparam int unsigned NS        = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
                                        CORDIC_STAGES : ATAN_TABLE_LEN;
    localparam int unsigned WHEEL_LAT = 3 + DIV_QUO_W;
    localparam int unsigned PULSE_DLY = WHEEL_LAT - NS - 2;
    localparam int unsigned LAT       = WHEEL_LAT + 1;
    localparam int unsigned SH        = 30 - ANGLE_FRAC_BITS;
    localparam int unsigned PROD_W    = ANGLE_FRAC_BITS + K_Q16_W;
    localparam logic [COR_ZW-1:0] ROUND_HALF = COR_ZW'(64'd1 << (SH - 1));
    localparam logic [COR_ZW-1:0] ANGLE_LIM  =
        COR_ZW'((LIMIT_Q30 + (64'd1 << (SH - 1))) >> SH);

    logic [AXLE_W-1:0]  axle_reg;
    logic [TRACK_W-1:0] track_reg;
    logic [WHEEL_W-1:0] wheel_reg;

    logic accept;

    logic                  straight;
    logic signed [19:0]    r2;
    logic signed [19:0]    t_s;
    logic signed [19:0]    a_l;
    logic signed [19:0]    a_r;
    logic [RADIUS_W-1:0]   ar_raw;
    logic [RADIUS_W-1:0]   ar_eff;
    logic [WHEEL_W-1:0]    d_eff;

    logic signed [35:0] s1_num_l_next;
    logic signed [35:0] s1_num_r_next;
    logic [27:0]        s1_ard_next;
    logic signed [35:0] s1_num_l_reg;
    logic signed [35:0] s1_num_r_reg;
    logic [27:0]        s1_ard_reg;
    logic               s1_rneg_reg;

    logic [33:0] mag_l;
    logic [33:0] mag_r;
    logic [55:0] s2_prod_l_next;
    logic [55:0] s2_prod_r_next;
    logic [55:0] s2_prod_l_reg;
    logic [55:0] s2_prod_r_reg;
    logic [27:0] s2_ard_reg;
    logic        s2_neg_l_reg;
    logic        s2_neg_r_reg;

    logic [DIV_REM_W-1:0] s3_sum_l_next;
    logic [DIV_REM_W-1:0] s3_sum_r_next;
    logic [DIV_REM_W-1:0] s3_sum_l_reg;
    logic [DIV_REM_W-1:0] s3_sum_r_reg;
    logic [27:0]          s3_ard_reg;
    logic                 s3_neg_l_reg;
    logic                 s3_neg_r_reg;
    logic [DIV_DEN_W-1:0] s3_den;

    div_slot_t div_l [DIV_QUO_W+1];
    div_slot_t div_r [DIV_QUO_W+1];
    cor_slot_t cor   [NS+1];

    logic [COR_ZW-1:0]          zmag;
    logic [COR_ZW-1:0]          zrnd;
    logic [ANGLE_FRAC_BITS-1:0] amag_next;
    logic                       aneg_next;
    logic [ANGLE_FRAC_BITS-1:0] amag_reg;
    logic                       aneg_reg;
    logic [PROD_W-1:0]          aprod;
    logic [PULSE_W-1:0]         off;
    logic [PULSE_W-1:0]         pulse_next;
    logic [PULSE_W-1:0]         pulse_reg;
    logic [PULSE_W-1:0]         pulse_dly_reg [PULSE_DLY];

    logic [WHEEL_LAT-1:0]     vld_reg;
    logic                     done_reg;
    logic signed [RPS_W-1:0]  left_reg;
    logic signed [RPS_W-1:0]  right_reg;
    logic [PULSE_W-1:0]       steer_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axle_reg  <= AXLE_RESET;
            track_reg <= TRACK_RESET;
            wheel_reg <= WHEEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AXLE:  axle_reg  <= AXLE_W'(cfg_data);
                CFG_TRACK: track_reg <= TRACK_W'(cfg_data);
                CFG_WHEEL: wheel_reg <= WHEEL_W'(cfg_data);
                default:   ;
            endcase
        end
    end

    // A straight-ahead request is worked as a radius of one with no track offset.
    assign straight = turn_radius == '0;
    assign r2       = $signed({turn_radius[RADIUS_W-1], turn_radius, 1'b0});
    assign t_s      = $signed({9'b0, track_reg});
    assign a_l      = straight ? 20'sd2 : r2 - t_s;
    assign a_r      = straight ? 20'sd2 : r2 + t_s;
    assign ar_raw   = turn_radius[RADIUS_W-1] ? RADIUS_W'(-turn_radius) :
                                                RADIUS_W'(turn_radius);
    assign ar_eff   = straight ? RADIUS_W'(1) : ar_raw;
    assign d_eff    = (wheel_reg == '0) ? WHEEL_W'(1) : wheel_reg;

    assign s1_num_l_next = forward_speed * a_l;
    assign s1_num_r_next = forward_speed * a_r;
    assign s1_ard_next   = 28'(ar_eff) * 28'(d_eff);

    always_ff @(posedge clk)
    begin
        s1_num_l_reg <= s1_num_l_next;
        s1_num_r_reg <= s1_num_r_next;
        s1_ard_reg   <= s1_ard_next;
        s1_rneg_reg  <= turn_radius[RADIUS_W-1];
    end

    assign mag_l = s1_num_l_reg[35] ? 34'(-s1_num_l_reg) : 34'(s1_num_l_reg);
    assign mag_r = s1_num_r_reg[35] ? 34'(-s1_num_r_reg) : 34'(s1_num_r_reg);
    assign s2_prod_l_next = 56'(mag_l) * 56'(INV_PI_Q24);
    assign s2_prod_r_next = 56'(mag_r) * 56'(INV_PI_Q24);

    always_ff @(posedge clk)
    begin
        s2_prod_l_reg <= s2_prod_l_next;
        s2_prod_r_reg <= s2_prod_r_next;
        s2_ard_reg    <= s1_ard_reg;
        s2_neg_l_reg  <= s1_num_l_reg[35] ^ s1_rneg_reg;
        s2_neg_r_reg  <= s1_num_r_reg[35] ^ s1_rneg_reg;
    end

    assign s3_sum_l_next = DIV_REM_W'(s2_prod_l_reg) + DIV_REM_W'({s2_ard_reg, 8'b0});
    assign s3_sum_r_next = DIV_REM_W'(s2_prod_r_reg) + DIV_REM_W'({s2_ard_reg, 8'b0});

    always_ff @(posedge clk)
    begin
        s3_sum_l_reg <= s3_sum_l_next;
        s3_sum_r_reg <= s3_sum_r_next;
        s3_ard_reg   <= s2_ard_reg;
        s3_neg_l_reg <= s2_neg_l_reg;
        s3_neg_r_reg <= s2_neg_r_reg;
    end

    assign s3_den = {s3_ard_reg, 9'b0};

    // Quotients of 2^33 or more are flagged here and saturate at the end.
    always_comb
    begin
        div_l[0].rem = s3_sum_l_reg;
        div_l[0].den = s3_den;
        div_l[0].quo = '0;
        div_l[0].neg = s3_neg_l_reg;
        div_l[0].ovf = 70'(s3_sum_l_reg) >= (70'(s3_den) << DIV_QUO_W);
        div_r[0].rem = s3_sum_r_reg;
        div_r[0].den = s3_den;
        div_r[0].quo = '0;
        div_r[0].neg = s3_neg_r_reg;
        div_r[0].ovf = 70'(s3_sum_r_reg) >= (70'(s3_den) << DIV_QUO_W);
    end

    for (genvar k = 0; k < DIV_QUO_W; k++)
    begin : g_div
        akd_div_cell #(.BIT(DIV_QUO_W - 1 - k)) u_left (
            .clk      (clk),
            .slot_in  (div_l[k]),
            .slot_out (div_l[k+1])
        );
        akd_div_cell #(.BIT(DIV_QUO_W - 1 - k)) u_right (
            .clk      (clk),
            .slot_in  (div_r[k]),
            .slot_out (div_r[k+1])
        );
    end

    always_comb
    begin
        cor[0].x        = $signed(COR_XW'({ar_raw, 20'b0}));
        cor[0].y        = $signed(COR_XW'({axle_reg, 20'b0}));
        cor[0].z        = '0;
        cor[0].rneg     = turn_radius[RADIUS_W-1];
        cor[0].straight = straight;
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        akd_cordic_cell #(.IDX(i)) u_cell (
            .clk      (clk),
            .slot_in  (cor[i]),
            .slot_out (cor[i+1])
        );
    end

    assign zmag = cor[NS].z[COR_ZW-1] ? COR_ZW'(-cor[NS].z) : COR_ZW'(cor[NS].z);
    assign zrnd = (zmag + ROUND_HALF) >> SH;
    assign amag_next = cor[NS].straight ? '0 :
                       ANGLE_FRAC_BITS'((zrnd > ANGLE_LIM) ? ANGLE_LIM : zrnd);
    assign aneg_next = cor[NS].z[COR_ZW-1] ^ cor[NS].rneg;

    always_ff @(posedge clk)
    begin
        amag_reg <= amag_next;
        aneg_reg <= aneg_next;
    end

    assign aprod = PROD_W'(amag_reg) * PROD_W'(K_Q16);
    assign off   = PULSE_W'((aprod + (PROD_W'(1) << (ANGLE_FRAC_BITS + 15)))
                            >> (ANGLE_FRAC_BITS + 16));
    assign pulse_next = aneg_reg ? PULSE_CENTRE + off : PULSE_CENTRE - off;

    always_ff @(posedge clk)
    begin
        pulse_reg        <= pulse_next;
        pulse_dly_reg[0] <= pulse_reg;
        for (int j = 1; j < PULSE_DLY; j++)
        begin
            pulse_dly_reg[j] <= pulse_dly_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[WHEEL_LAT-2:0], accept};
            done_reg <= vld_reg[WHEEL_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= akd_saturate(div_l[DIV_QUO_W]);
        right_reg <= akd_saturate(div_r[DIV_QUO_W]);
        steer_reg <= pulse_dly_reg[PULSE_DLY-1];
    end

    assign done        = done_reg;
    assign left_rps    = left_reg;
    assign right_rps   = right_reg;
    assign steer_pulse = steer_reg;

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (steer_pulse >= PULSE_MIN && steer_pulse <= PULSE_MAX))
        else $error("steering pulse outside the clamped range");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without a matching request");

    a_straight: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(accept && turn_radius == '0, LAT)) |->
        (left_rps == right_rps && steer_pulse == PULSE_CENTRE))
        else $error("straight-ahead request gave unequal wheels or off-centre pulse");

endmodule
